// File: design/hdcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hdcb_pkg;

  // Field and register widths.
  localparam int DIM_W   = 13;  // frame_width / frame_height registers
  localparam int POS_W   = 12;  // luma row / column
  localparam int HALF_W  = 11;  // halved row / column
  localparam int SPAN_W  = 12;  // half-grid span minus one
  localparam int CODE_W  = 10;  // Y / Pb / Pr codes
  localparam int ROWX_W  = 16;  // 12*r and k*h1 products
  localparam int COLX_W  = 17;  // 56*c
  localparam int PROD_W  = 18;  // n*w1 bar edges
  localparam int DIFF_W  = 17;  // 56*c - 13*w1 inside the ramp
  localparam int NUM_W   = 27;  // 876 * diff
  localparam int DIV_W   = 17;  // 30 * w1
  localparam int QUO_W   = 10;  // ramp quotient bits
  localparam int BAND_W  = 2;
  localparam int IDX_W   = 4;
  localparam int THR_N   = 14;  // distinct bar edges over all bands
  localparam int THR_W   = 6;
  localparam int CFG_IDX_W = 1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd1920;
  localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd1080;

  // Band codes, top to bottom.
  localparam logic [BAND_W-1:0] BAND_BARS  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_REV   = 2'd1;
  localparam logic [BAND_W-1:0] BAND_RAMP  = 2'd2;
  localparam logic [BAND_W-1:0] BAND_PLUGE = 2'd3;

  // Band edges in twelfths of the grid height.
  localparam int BAND_EDGE0 = 7;
  localparam int BAND_EDGE1 = 8;
  localparam int BAND_EDGE2 = 9;
  localparam int ROW_SCALE  = 12;
  localparam int COL_SCALE  = 56;
  localparam int RAMP_START = 13;
  localparam int RAMP_SPAN  = 30;

  localparam logic [CODE_W-1:0] RAMP_BASE  = 10'd64;
  localparam logic [CODE_W-1:0] RAMP_SCALE = 10'd876;

  // All bar right edges, in 56ths of the grid width, ascending.
  localparam logic [THR_N-1:0][THR_W-1:0] THR = {
    6'd49, 6'd43, 6'd41, 6'd39, 6'd37, 6'd35, 6'd33,
    6'd31, 6'd28, 6'd25, 6'd19, 6'd16, 6'd13, 6'd7
  };

  // Which of the edges above belong to each band.
  localparam logic [3:0][THR_N-1:0] BAND_MASK = {
    14'b11_1111_1010_0101,  // pluge band
    14'b11_0000_0000_0011,  // ramp band
    14'b10_0000_0000_0011,  // reverse bars
    14'b11_0010_0101_1011   // main bars
  };

  typedef struct packed {
    logic [POS_W-1:0] pixel_row;
    logic [POS_W-1:0] pixel_col;
  } pix_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] luma_code;
    logic [CODE_W-1:0] blue_diff_code;
    logic [CODE_W-1:0] red_diff_code;
  } code_word_t;

  typedef struct packed {
    logic              ramp;
    logic [CODE_W-1:0] y;
    logic [CODE_W-1:0] pb;
    logic [CODE_W-1:0] pr;
  } color_t;

  // Thresholds derived from the frame registers.
  typedef struct packed {
    logic [THR_N-1:0][PROD_W-1:0] thr_w;
    logic [ROWX_W-1:0]            h7;
    logic [ROWX_W-1:0]            h8;
    logic [ROWX_W-1:0]            h9;
    logic [PROD_W-1:0]            w13;
  } deriv_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [THR_N-1:0]  ge;
    logic [DIFF_W-1:0] diff;
  } loc_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    color_t           color;
  } div_in_t;

  typedef struct packed {
    logic [QUO_W-1:0] quo;
    color_t           color;
  } div_out_t;

  function automatic color_t color_of(input int y, input int pb, input int pr);
    color_t c;
    c.ramp = 1'b0;
    c.y    = CODE_W'(y);
    c.pb   = CODE_W'(pb);
    c.pr   = CODE_W'(pr);
    return c;
  endfunction

  function automatic color_t color_lookup(input logic [BAND_W-1:0] band,
                                          input logic [IDX_W-1:0] idx);
    color_t c;
    c = color_of(64, 512, 512);
    case (band)
      BAND_BARS: begin
        case (idx)
          4'd0: c = color_of(414, 512, 512);
          4'd1: c = color_of(721, 512, 512);
          4'd2: c = color_of(674, 176, 543);
          4'd3: c = color_of(581, 589, 176);
          4'd4: c = color_of(534, 253, 207);
          4'd5: c = color_of(251, 771, 817);
          4'd6: c = color_of(204, 435, 848);
          4'd7: c = color_of(111, 848, 481);
          4'd8: c = color_of(414, 512, 512);
          default: c = color_of(64, 512, 512);
        endcase
      end
      BAND_REV: begin
        case (idx)
          4'd0: c = color_of(754, 615, 64);
          4'd1: c = color_of(245, 412, 629);
          4'd2: c = color_of(721, 512, 512);
          4'd3: c = color_of(127, 960, 471);
          default: c = color_of(64, 512, 512);
        endcase
      end
      BAND_RAMP: begin
        case (idx)
          4'd0: c = color_of(877, 64, 553);
          4'd1: c = color_of(64, 512, 512);
          4'd2: begin
            c = color_of(0, 512, 512);
            c.ramp = 1'b1;
          end
          4'd3: c = color_of(940, 512, 512);
          4'd4: c = color_of(250, 409, 950);
          default: c = color_of(64, 512, 512);
        endcase
      end
      BAND_PLUGE: begin
        case (idx)
          4'd0:  c = color_of(195, 512, 512);
          4'd1:  c = color_of(64, 512, 512);
          4'd2:  c = color_of(940, 512, 512);
          4'd3:  c = color_of(64, 512, 512);
          4'd4:  c = color_of(46, 512, 512);
          4'd5:  c = color_of(64, 512, 512);
          4'd6:  c = color_of(82, 512, 512);
          4'd7:  c = color_of(64, 512, 512);
          4'd8:  c = color_of(99, 512, 512);
          4'd9:  c = color_of(64, 512, 512);
          4'd10: c = color_of(195, 512, 512);
          default: c = color_of(64, 512, 512);
        endcase
      end
      default: c = color_of(64, 512, 512);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/hdcb_locate.sv
`timescale 1ns / 1ps
`default_nettype none

module hdcb_locate (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hdcb_pkg::pix_word_t in_word,
  input  hdcb_pkg::deriv_t   deriv,
  output logic               out_valid,
  input  logic               out_ready,
  output hdcb_pkg::loc_t     out_word
);
  import hdcb_pkg::*;

  logic              v1_r, v2_r, v3_r;
  logic              en1, en2, en3;
  logic [HALF_W-1:0] row_r, col_r;
  logic [ROWX_W-1:0] row12_r;
  logic [COLX_W-1:0] col56_r;
  loc_t              loc_r;
  loc_t              loc_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  // Band and bar edge tests against the cross-multiplied thresholds.
  always_comb begin
    if (row12_r < deriv.h7) begin
      loc_nxt.band = BAND_BARS;
    end else if (row12_r < deriv.h8) begin
      loc_nxt.band = BAND_REV;
    end else if (row12_r < deriv.h9) begin
      loc_nxt.band = BAND_RAMP;
    end else begin
      loc_nxt.band = BAND_PLUGE;
    end
    for (int j = 0; j < THR_N; j++) begin
      loc_nxt.ge[j] = !(PROD_W'(col56_r) < deriv.thr_w[j]);
    end
    loc_nxt.diff = DIFF_W'(PROD_W'(col56_r) - deriv.w13);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      row_r <= in_word.pixel_row[POS_W-1:1];
      col_r <= in_word.pixel_col[POS_W-1:1];
    end
    if (en2) begin
      row12_r <= (ROWX_W'(row_r) << 3) + (ROWX_W'(row_r) << 2);
      col56_r <= (COLX_W'(col_r) << 6) - (COLX_W'(col_r) << 3);
    end
    if (en3) begin
      loc_r <= loc_nxt;
    end
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_word  = loc_r;

endmodule

`default_nettype wire

// File: design/hdcb_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module hdcb_palette (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hdcb_pkg::loc_t    in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output hdcb_pkg::div_in_t out_word
);
  import hdcb_pkg::*;

  logic             valid_r;
  logic             en;
  logic [IDX_W-1:0] idx;
  logic [THR_N-1:0] hits;
  div_in_t          word_r;

  assign en       = !valid_r || out_ready;
  assign in_ready = en;

  // Bar index is the number of this band's edges the column has passed.
  always_comb begin
    hits = in_word.ge & BAND_MASK[in_word.band];
    idx  = '0;
    for (int j = 0; j < THR_N; j++) begin
      idx = idx + IDX_W'(hits[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r.color <= color_lookup(in_word.band, idx);
      word_r.num   <= NUM_W'(in_word.diff) * NUM_W'(RAMP_SCALE);
    end
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// File: design/hdcb_ramp_div.sv
`timescale 1ns / 1ps
`default_nettype none

module hdcb_ramp_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hdcb_pkg::div_in_t          in_word,
  input  logic [hdcb_pkg::DIV_W-1:0] divisor,
  output logic                       out_valid,
  input  logic                       out_ready,
  output hdcb_pkg::div_out_t         out_word
);
  import hdcb_pkg::*;

  localparam int REM_W_C = NUM_W;

  // One restoring quotient bit per stage, most significant bit first.
  logic [QUO_W-1:0] valid_r;
  logic [QUO_W-1:0] en;
  logic [QUO_W-1:0] v_in;
  logic [REM_W_C-1:0] rem_r   [QUO_W];
  logic [REM_W_C-1:0] rem_in  [QUO_W];
  logic [REM_W_C-1:0] rem_nxt [QUO_W];
  logic [REM_W_C-1:0] dsh     [QUO_W];
  logic [QUO_W-1:0]   quo_r   [QUO_W];
  logic [QUO_W-1:0]   quo_in  [QUO_W];
  logic [QUO_W-1:0]   quo_nxt [QUO_W];
  color_t             color_r [QUO_W];
  color_t             color_in [QUO_W];

  always_comb begin
    en[QUO_W-1] = !valid_r[QUO_W-1] || out_ready;
    for (int i = QUO_W - 2; i >= 0; i--) begin
      en[i] = !valid_r[i] || en[i+1];
    end
  end

  assign in_ready = en[0];

  always_comb begin
    v_in[0]     = in_valid;
    rem_in[0]   = in_word.num;
    quo_in[0]   = '0;
    color_in[0] = in_word.color;
    for (int k = 1; k < QUO_W; k++) begin
      v_in[k]     = valid_r[k-1];
      rem_in[k]   = rem_r[k-1];
      quo_in[k]   = quo_r[k-1];
      color_in[k] = color_r[k-1];
    end
    for (int k = 0; k < QUO_W; k++) begin
      dsh[k] = REM_W_C'(divisor) << (QUO_W - 1 - k);
      if (rem_in[k] >= dsh[k]) begin
        rem_nxt[k] = rem_in[k] - dsh[k];
        quo_nxt[k] = quo_in[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem_nxt[k] = rem_in[k];
        quo_nxt[k] = quo_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < QUO_W; k++) begin
      if (en[k]) begin
        rem_r[k]   <= rem_nxt[k];
        quo_r[k]   <= quo_nxt[k];
        color_r[k] <= color_in[k];
      end
    end
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int k = 0; k < QUO_W; k++) begin
        if (en[k]) valid_r[k] <= v_in[k];
      end
    end
  end

  assign out_valid      = valid_r[QUO_W-1];
  assign out_word.quo   = quo_r[QUO_W-1];
  assign out_word.color = color_r[QUO_W-1];

endmodule

`default_nettype wire

// File: design/hd_color_bar_pattern.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one word per clock unless out_ready stalls the output; three locate
// stages, one palette stage, ten divider stages (one ramp quotient bit each) and
// one output register.
// Reset (rst_n low at a clock edge) empties the pipeline and returns the frame
// registers to 1920 x 1080.

module hd_color_bar_pattern #(
  parameter int MAX_DIM = 4096
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  hdcb_pkg::pix_word_t            in_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output hdcb_pkg::code_word_t           out_word,
  input  logic                           cfg_we,
  input  logic [hdcb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hdcb_pkg::DIM_W-1:0]     cfg_data
);
  import hdcb_pkg::*;

  // A written frame size saturates at MAX_DIM; the register cannot hold more
  // than its own width allows, so a larger MAX_DIM never clips.
  localparam int REG_MAX = (1 << DIM_W) - 1;
  localparam int SAT_INT = (MAX_DIM > REG_MAX) ? REG_MAX : MAX_DIM;
  localparam logic [DIM_W-1:0] SAT = DIM_W'(SAT_INT);

  logic [DIM_W-1:0]  frame_width_r;
  logic [DIM_W-1:0]  frame_height_r;
  logic [DIM_W-1:0]  cfg_sat;
  logic [SPAN_W-1:0] w1, h1;
  deriv_t            deriv_r;
  logic [DIV_W-1:0]  d30_r;

  logic     loc_valid, loc_ready;
  loc_t     loc_word;
  logic     pal_valid, pal_ready;
  div_in_t  pal_word;
  logic     div_valid, div_ready;
  div_out_t div_word;

  logic       out_valid_r;
  code_word_t out_word_r;
  logic       out_en;

  // Span of the half-resolution grid, never below one.
  function automatic logic [SPAN_W-1:0] span_of(input logic [DIM_W-1:0] dim);
    logic [DIM_W-1:0] half;
    half = DIM_W'(({1'b0, dim} + (DIM_W + 1)'(1)) >> 1);
    return (half >= DIM_W'(2)) ? SPAN_W'(half - DIM_W'(1)) : SPAN_W'(1);
  endfunction

  // Configuration registers.
  assign cfg_sat = (cfg_data > SAT) ? SAT : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RESET_WIDTH;
      frame_height_r <= RESET_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width_r  <= cfg_sat;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_sat;
        default: ;
      endcase
    end
  end

  // The thresholds depend only on the frame registers, so they are registered
  // once here and shared by every word. After a write they settle from the new
  // frame registers before a newly accepted word reaches the compare stage.
  assign w1 = span_of(frame_width_r);
  assign h1 = span_of(frame_height_r);

  always_ff @(posedge clk) begin
    for (int j = 0; j < THR_N; j++) begin
      deriv_r.thr_w[j] <= PROD_W'(w1) * PROD_W'(THR[j]);
    end
    deriv_r.h7  <= ROWX_W'(h1) * ROWX_W'(BAND_EDGE0);
    deriv_r.h8  <= ROWX_W'(h1) * ROWX_W'(BAND_EDGE1);
    deriv_r.h9  <= ROWX_W'(h1) * ROWX_W'(BAND_EDGE2);
    deriv_r.w13 <= PROD_W'(w1) * PROD_W'(RAMP_START);
    d30_r       <= DIV_W'(w1) * DIV_W'(RAMP_SPAN);
  end

  // Halve the position, scale it and sort it into band and bar edges.
  hdcb_locate u_locate (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .deriv     (deriv_r),
    .out_valid (loc_valid),
    .out_ready (loc_ready),
    .out_word  (loc_word)
  );

  // Pick the bar color and form the ramp numerator 876*(56c - 13*w1).
  hdcb_palette u_palette (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (loc_valid),
    .in_ready  (loc_ready),
    .in_word   (loc_word),
    .out_valid (pal_valid),
    .out_ready (pal_ready),
    .out_word  (pal_word)
  );

  // Divide by 30*w1. Inside the ramp the numerator is below 876 times the
  // divisor, so ten quotient bits are exact; elsewhere the quotient is unused.
  hdcb_ramp_div u_ramp_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (pal_valid),
    .in_ready  (pal_ready),
    .in_word   (pal_word),
    .divisor   (d30_r),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_word  (div_word)
  );

  // Output register: ramp luma is the quotient above black, every other bar
  // takes its luma straight from the palette.
  assign out_en    = !out_valid_r || out_ready;
  assign div_ready = out_en;

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_word_r.luma_code      <= div_word.color.ramp ?
                                   CODE_W'(RAMP_BASE + div_word.quo) :
                                   div_word.color.y;
      out_word_r.blue_diff_code <= div_word.color.pb;
      out_word_r.red_diff_code  <= div_word.color.pr;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

`ifndef SYNTHESIS
  // Input back-pressure only arises when every stage is full and the output
  // is stalled.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while the pipeline could move");

  // A ramp quotient must stay within the 876-code luma swing.
  a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_valid && div_word.color.ramp) |-> (div_word.quo < QUO_W'(RAMP_SCALE)))
    else $error("ramp quotient out of range");

  // Once out of reset the ramp divisor is never zero.
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (d30_r != '0))
    else $error("ramp divisor is zero");
`endif

endmodule

`default_nettype wire

// File: sim/tb_hd_color_bar_pattern.sv
`timescale 1ns / 1ps

module tb_hd_color_bar_pattern;
  import hdcb_pkg::*;

  // Clock period is 8 ns. The run is stopped here if it hangs.
  localparam int CYCLE_LIMIT = 100000;
  // Length of the one long back-pressure episode on the result side.
  localparam int LONG_HOLD = 300;
  // Cycles allowed after the last result for any stray word to show up.
  localparam int DRAIN_CYCLES = 40;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  pix_word_t  in_word = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  code_word_t out_word;
  logic       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_FRAME_WIDTH;
  logic [DIM_W-1:0]     cfg_data = '0;

  // Pixel words waiting to be offered, and code words the pattern should return.
  pix_word_t  pix_backlog[$];
  code_word_t due_codes[$];

  // Our own copy of the frame registers, as the block should hold them.
  int frame_w = 1920;
  int frame_h = 1080;

  // Traffic shaping, written by the sequencer just after a rising edge.
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  // Owned by the result-side process.
  bit hold_done = 1'b0;
  int hold_left = 0;

  // Set at a rising edge when the word on the input was taken.
  logic in_took = 1'b0;

  int errors = 0;
  int words_sent = 0;
  int codes_checked = 0;
  int settings_used = 1;
  int cycle_count = 0;

  hd_color_bar_pattern DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // Pattern predictor
  // ---------------------------------------------------------------------

  // The half-resolution grid spans (dim+1)/2 cells; edges are measured
  // against that count minus one, never allowed to drop below one.
  function automatic longint grid_span(input int dim);
    int half;
    half = (dim + 1) >> 1;
    return (half >= 2) ? longint'(half - 1) : 64'd1;
  endfunction

  function automatic int bars_in_band(input logic [BAND_W-1:0] band);
    case (band)
      BAND_BARS: return 8;
      BAND_REV:  return 3;
      BAND_RAMP: return 4;
      default:   return 10;
    endcase
  endfunction

  // Right edge of bar i inside a band, in 56ths of the grid width.
  function automatic int bar_right_edge(input logic [BAND_W-1:0] band, input int i);
    int e;
    e = 56;
    case (band)
      BAND_BARS: begin
        case (i)
          0: e = 7;
          1: e = 13;
          2: e = 19;
          3: e = 25;
          4: e = 31;
          5: e = 37;
          6: e = 43;
          7: e = 49;
          default: e = 56;
        endcase
      end
      BAND_REV: begin
        case (i)
          0: e = 7;
          1: e = 13;
          2: e = 49;
          default: e = 56;
        endcase
      end
      BAND_RAMP: begin
        case (i)
          0: e = 7;
          1: e = 13;
          2: e = 43;
          3: e = 49;
          default: e = 56;
        endcase
      end
      default: begin
        case (i)
          0: e = 7;
          1: e = 16;
          2: e = 28;
          3: e = 33;
          4: e = 35;
          5: e = 37;
          6: e = 39;
          7: e = 41;
          8: e = 43;
          9: e = 49;
          default: e = 56;
        endcase
      end
    endcase
    return e;
  endfunction

  function automatic code_word_t ypbpr(input int y, input int pb, input int pr);
    code_word_t cw;
    cw.luma_code      = y[CODE_W-1:0];
    cw.blue_diff_code = pb[CODE_W-1:0];
    cw.red_diff_code  = pr[CODE_W-1:0];
    return cw;
  endfunction

  // Fixed color of bar i in a band. The ramp bar reports itself through
  // is_ramp; its luma is worked out by the caller.
  function automatic code_word_t bar_palette(input logic [BAND_W-1:0] band, input int i,
                                             output bit is_ramp);
    code_word_t cw;
    is_ramp = 1'b0;
    cw = ypbpr(64, 512, 512);
    case (band)
      BAND_BARS: begin
        case (i)
          0: cw = ypbpr(414, 512, 512);
          1: cw = ypbpr(721, 512, 512);
          2: cw = ypbpr(674, 176, 543);
          3: cw = ypbpr(581, 589, 176);
          4: cw = ypbpr(534, 253, 207);
          5: cw = ypbpr(251, 771, 817);
          6: cw = ypbpr(204, 435, 848);
          7: cw = ypbpr(111, 848, 481);
          default: cw = ypbpr(414, 512, 512);
        endcase
      end
      BAND_REV: begin
        case (i)
          0: cw = ypbpr(754, 615, 64);
          1: cw = ypbpr(245, 412, 629);
          2: cw = ypbpr(721, 512, 512);
          default: cw = ypbpr(127, 960, 471);
        endcase
      end
      BAND_RAMP: begin
        case (i)
          0: cw = ypbpr(877, 64, 553);
          1: cw = ypbpr(64, 512, 512);
          2: begin
            cw = ypbpr(0, 512, 512);
            is_ramp = 1'b1;
          end
          3: cw = ypbpr(940, 512, 512);
          default: cw = ypbpr(250, 409, 950);
        endcase
      end
      default: begin
        // Pluge band: black surround with the sub-black and super-black steps.
        case (i)
          0: cw = ypbpr(195, 512, 512);
          2: cw = ypbpr(940, 512, 512);
          4: cw = ypbpr(46, 512, 512);
          6: cw = ypbpr(82, 512, 512);
          8: cw = ypbpr(99, 512, 512);
          10: cw = ypbpr(195, 512, 512);
          default: cw = ypbpr(64, 512, 512);
        endcase
      end
    endcase
    return cw;
  endfunction

  function automatic code_word_t expected_bar_code(input pix_word_t px, input int fw,
                                                   input int fh);
    longint r;
    longint c;
    longint w1;
    longint h1;
    longint ramp_num;
    logic [BAND_W-1:0] band;
    int i;
    bit is_ramp;
    code_word_t cw;
    r  = longint'(px.pixel_row >> 1);
    c  = longint'(px.pixel_col >> 1);
    w1 = grid_span(fw);
    h1 = grid_span(fh);
    // Band split at 7/12, 8/12 and 9/12 of the grid height, compared exactly.
    if (12 * r < 7 * h1) band = BAND_BARS;
    else if (12 * r < 8 * h1) band = BAND_REV;
    else if (12 * r < 9 * h1) band = BAND_RAMP;
    else band = BAND_PLUGE;
    // Walk the bars until the column falls left of a right edge; anything
    // past the last edge, including columns beyond the frame, is the tail.
    i = 0;
    while (i < bars_in_band(band) && !(56 * c < longint'(bar_right_edge(band, i)) * w1))
      i++;
    cw = bar_palette(band, i, is_ramp);
    if (is_ramp) begin
      ramp_num = 876 * (56 * c - 13 * w1);
      cw.luma_code = CODE_W'(64 + ramp_num / (30 * w1));
    end
    return cw;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // Every distinct bar edge over all bands, in 56ths.
  function automatic int any_bar_edge(input int k);
    case (k)
      0: return 7;
      1: return 13;
      2: return 16;
      3: return 19;
      4: return 25;
      5: return 28;
      6: return 31;
      7: return 33;
      8: return 35;
      9: return 37;
      10: return 39;
      11: return 41;
      12: return 43;
      default: return 49;
    endcase
  endfunction

  // A luma position whose halved value sits within two cells of
  // num/den of the grid span, with a random low bit.
  function automatic logic [POS_W-1:0] near_edge(input longint span, input int num,
                                                 input int den);
    longint half;
    half = (longint'(num) * span) / den + longint'($urandom_range(4)) - 2;
    if (half < 0) half = 0;
    if (half > 2047) half = 2047;
    return POS_W'(2 * half + $urandom_range(1));
  endfunction

  // Random pixel word: mostly inside the current frame or hugging a band or
  // bar edge, with some fully random words and some from the frame's last row or column out to 4095.
  function automatic pix_word_t random_pixel(input int fw, input int fh);
    pix_word_t px;
    int pick;
    int row_top;
    int col_top;
    pick = $urandom_range(99);
    row_top = (fh > 4096) ? 4095 : ((fh > 0) ? fh - 1 : 0);
    col_top = (fw > 4096) ? 4095 : ((fw > 0) ? fw - 1 : 0);
    if (pick < 40) begin
      px.pixel_row = POS_W'($urandom_range(row_top));
      px.pixel_col = POS_W'($urandom_range(col_top));
    end else if (pick < 72) begin
      px.pixel_row = near_edge(grid_span(fh), 7 + $urandom_range(2), 12);
      px.pixel_col = near_edge(grid_span(fw), any_bar_edge($urandom_range(13)), 56);
    end else if (pick < 90) begin
      px = pix_word_t'($urandom);
    end else begin
      px.pixel_row = POS_W'($urandom_range(4095, row_top));
      px.pixel_col = POS_W'($urandom_range(4095, col_top));
    end
    return px;
  endfunction

  // ---------------------------------------------------------------------
  // Input driver: a new word is offered only once the current one has been
  // taken, and unless no_idle is set it leaves the input empty about one time in six instead.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pix_backlog.size() != 0 && (no_idle || $urandom_range(99) >= 17)) begin
        in_word  <= pix_backlog.pop_front();
        in_valid <= 1'b1;
        words_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result-side ready: random stalls, plus one long hold-off counted here so
  // that the pipeline fills and pushes back on the input.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 17);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every accepted pixel word gets its predicted code word queued,
  // and every accepted code word is checked against the oldest one waiting.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    code_word_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (in_valid && in_ready)
        due_codes.push_back(expected_bar_code(in_word, frame_w, frame_h));
      if (out_valid && out_ready) begin
        if (due_codes.size() == 0) begin
          $display("%0t: unexpected code word Y=%0d Pb=%0d Pr=%0d", $time,
                   out_word.luma_code, out_word.blue_diff_code, out_word.red_diff_code);
          errors++;
        end else begin
          want = due_codes.pop_front();
          codes_checked++;
          if (out_word.luma_code !== want.luma_code) begin
            $display("%0t: Y mismatch, expected %0d, got %0d", $time,
                     want.luma_code, out_word.luma_code);
            errors++;
          end
          if (out_word.blue_diff_code !== want.blue_diff_code) begin
            $display("%0t: Pb mismatch, expected %0d, got %0d", $time,
                     want.blue_diff_code, out_word.blue_diff_code);
            errors++;
          end
          if (out_word.red_diff_code !== want.red_diff_code) begin
            $display("%0t: Pr mismatch, expected %0d, got %0d", $time,
                     want.red_diff_code, out_word.red_diff_code);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d code words outstanding", $time, due_codes.size());
      $display("tb_hd_color_bar_pattern: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------

  // Returns at a falling edge once every word has gone in and come back out.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (!(pix_backlog.size() == 0 && !in_valid && due_codes.size() == 0));
  endtask

  // One register write at a falling edge; our copy saturates as the block does.
  task automatic write_frame_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    int v;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[DIM_W-1:0];
    v = value & 32'h1FFF;
    if (v > 4096) v = 4096;
    if (idx == CFG_FRAME_WIDTH) frame_w = v;
    else frame_h = v;
  endtask

  // Reprogram the frame while the pattern is idle, then queue a batch of
  // random pixels. The sender pauses here until all earlier results are back.
  task automatic run_frame(input int fw, input int fh, input int count, input bit calm,
                           input bit long_hold);
    wait_until_drained();
    write_frame_reg(CFG_FRAME_WIDTH, fw);
    write_frame_reg(CFG_FRAME_HEIGHT, fh);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(posedge clk);
    no_idle = calm;
    hold_request = long_hold;
    repeat (count) pix_backlog.push_back(random_pixel(frame_w, frame_h));
  endtask

  initial begin
    pix_word_t px;
    longint w1;
    longint h1;
    int lo;
    int hi;
    logic [BAND_W-1:0] band;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset frame of 1920 x 1080: the far corners, then the
    // center of each bar in every band (only a sample of the main color bars), the ramp and pluge steps included.
    w1 = grid_span(frame_w);
    h1 = grid_span(frame_h);
    px.pixel_row = '1;
    px.pixel_col = '1;
    pix_backlog.push_back(px);
    px.pixel_row = '0;
    pix_backlog.push_back(px);
    for (int b = 0; b < 4; b++) begin
      band = b[BAND_W-1:0];
      lo = (b == 0) ? 0 : 6 + b;
      hi = (b == 3) ? 12 : 7 + b;
      px.pixel_row = POS_W'(2 * (((lo + hi) * h1) / 24));
      for (int i = 0; i <= bars_in_band(band); i++) begin
        // Only a sample of the main color bars; random traffic covers the rest.
        if (band != BAND_BARS || i == 0 || i == 4 || i == 8) begin
          lo = (i == 0) ? 0 : bar_right_edge(band, i - 1);
          hi = bar_right_edge(band, i);
          px.pixel_col = POS_W'(2 * (((lo + hi) * w1) / 112));
          pix_backlog.push_back(px);
        end
      end
    end
    repeat (200) pix_backlog.push_back(random_pixel(frame_w, frame_h));

    // Largest legal frame, no idling anywhere, and one long receiver hold-off
    // while the input keeps offering words.
    run_frame(4096, 4096, 250, 1'b1, 1'b1);
    // Writes above the maximum saturate; the width write has all register bits set.
    run_frame(8191, 5000, 200, 1'b0, 1'b0);
    // Smallest legal frame.
    run_frame(4, 4, 200, 1'b0, 1'b0);
    // A degenerate frame where the grid span is forced up to one.
    run_frame(1, 0, 150, 1'b0, 1'b0);
    run_frame(720, 486, 250, 1'b0, 1'b0);
    run_frame($urandom_range(4096, 4), $urandom_range(4096, 4), 200, 1'b0, 1'b0);
    run_frame(1920, 1080, 200, 1'b0, 1'b0);

    wait_until_drained();
    // Give any extra word from the pipeline a chance to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d pixel words over %0d frame settings and checked %0d code words.",
             words_sent, settings_used, codes_checked);
    $display("Frames ran from degenerate and minimum to saturated sizes, with positions "
             , "beyond the frame and a long output stall.");
    if (errors == 0) begin
      $display("tb_hd_color_bar_pattern: done, clean");
    end else begin
      $display("tb_hd_color_bar_pattern: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/hdcb_pkg.sv
design/hdcb_locate.sv
design/hdcb_palette.sv
design/hdcb_ramp_div.sv
design/hd_color_bar_pattern.sv
sim/tb_hd_color_bar_pattern.sv
